// ===== sv/fpvd_pkg.sv =====
package fpvd_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned LengthWidth = 28;
    localparam int unsigned LimitWidth  = 32;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned PendWidth   = 2;
    localparam int unsigned OutDataWidth = 32;

    localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_ENC_ERROR = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_UNUSED    = 2'd2;
    localparam logic [StatusWidth-1:0] STATUS_SHORT     = 2'd3;

    localparam logic [ByteWidth-1:0] LEAD1_MASK  = 8'h80;
    localparam logic [ByteWidth-1:0] LEAD2_MASK  = 8'hC0;
    localparam logic [ByteWidth-1:0] LEAD2_CODE  = 8'h80;
    localparam logic [ByteWidth-1:0] LEAD3_MASK  = 8'hE0;
    localparam logic [ByteWidth-1:0] LEAD3_CODE  = 8'hC0;
    localparam logic [ByteWidth-1:0] LEAD4_MASK  = 8'hF0;
    localparam logic [ByteWidth-1:0] LEAD4_CODE  = 8'hE0;
    localparam logic [ByteWidth-1:0] PAY2_MASK   = 8'h3F;
    localparam logic [ByteWidth-1:0] PAY3_MASK   = 8'h1F;
    localparam logic [ByteWidth-1:0] PAY4_MASK   = 8'h0F;

    typedef struct packed {
        logic                   pulse_valid;
        logic [LengthWidth-1:0] pulse_length;
        logic                   packet_done;
        logic [StatusWidth-1:0] final_status;
    } fpvd_result_t;

endpackage

// ===== sv/fpvd_in_stage.sv =====
module fpvd_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fpvd_pkg::ByteWidth-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            advance,
    output logic                            item_valid,
    output logic [fpvd_pkg::ByteWidth-1:0]  item_byte,
    output logic                            item_last
);

    logic                           valid_reg;
    logic [fpvd_pkg::ByteWidth-1:0] byte_reg;
    logic                           last_reg;

    // The register frees up in the same cycle its item moves on.
    assign s_axis_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;

endmodule

// ===== sv/fpvd_decode.sv =====
module fpvd_decode (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fpvd_pkg::LimitWidth-1:0]  cfg_wr_data,
    input  logic                             fire,
    input  logic [fpvd_pkg::ByteWidth-1:0]   item_byte,
    input  logic                             item_last,
    output logic                             has_result,
    output fpvd_pkg::fpvd_result_t           result
);

    logic [fpvd_pkg::LimitWidth-1:0]  limit_reg;
    logic [fpvd_pkg::PendWidth-1:0]   pend_reg, pend_next;
    logic [fpvd_pkg::LengthWidth-1:0] partial_reg, partial_next;
    logic [fpvd_pkg::LimitWidth-1:0]  count_reg, count_next;
    logic                             error_reg, error_next;
    logic                             unused_reg, unused_next;

    logic                             pulse;
    logic [fpvd_pkg::LengthWidth-1:0] shifted;
    logic [fpvd_pkg::LimitWidth-1:0]  count_inc;
    logic [fpvd_pkg::StatusWidth-1:0] status;

    always_comb begin
        pend_next    = pend_reg;
        partial_next = partial_reg;
        error_next   = error_reg;
        unused_next  = unused_reg;
        pulse        = 1'b0;
        shifted      = {partial_reg[fpvd_pkg::LengthWidth-fpvd_pkg::ByteWidth-1:0], item_byte};
        result.pulse_length = '0;

        if (error_reg) begin
            // Decoding has halted; the rest of the packet is dropped.
        end else if (pend_reg != '0) begin
            pend_next = pend_reg - 1'b1;
            if (pend_reg == 2'd1) begin
                pulse               = 1'b1;
                result.pulse_length = shifted;
                partial_next        = '0;
            end else begin
                partial_next = shifted;
            end
        end else if (count_reg >= limit_reg) begin
            unused_next = 1'b1;
        end else if ((item_byte & fpvd_pkg::LEAD1_MASK) == '0) begin
            pulse               = 1'b1;
            result.pulse_length = fpvd_pkg::LengthWidth'(item_byte);
        end else if ((item_byte & fpvd_pkg::LEAD2_MASK) == fpvd_pkg::LEAD2_CODE) begin
            partial_next = fpvd_pkg::LengthWidth'(item_byte & fpvd_pkg::PAY2_MASK);
            pend_next    = 2'd1;
        end else if ((item_byte & fpvd_pkg::LEAD3_MASK) == fpvd_pkg::LEAD3_CODE) begin
            partial_next = fpvd_pkg::LengthWidth'(item_byte & fpvd_pkg::PAY3_MASK);
            pend_next    = 2'd2;
        end else if ((item_byte & fpvd_pkg::LEAD4_MASK) == fpvd_pkg::LEAD4_CODE) begin
            partial_next = fpvd_pkg::LengthWidth'(item_byte & fpvd_pkg::PAY4_MASK);
            pend_next    = 2'd3;
        end else begin
            error_next = 1'b1;
        end

        count_inc  = count_reg + 1'b1;
        count_next = pulse ? count_inc : count_reg;

        if (error_next || pend_next != '0) begin
            status = fpvd_pkg::STATUS_ENC_ERROR;
        end else if (unused_next) begin
            status = fpvd_pkg::STATUS_UNUSED;
        end else if (count_next != limit_reg) begin
            status = fpvd_pkg::STATUS_SHORT;
        end else begin
            status = fpvd_pkg::STATUS_OK;
        end

        result.pulse_valid  = pulse;
        result.packet_done  = item_last;
        result.final_status = item_last ? status : fpvd_pkg::STATUS_OK;
        has_result          = pulse || item_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            partial_reg <= '0;
            count_reg   <= '0;
            error_reg   <= 1'b0;
            unused_reg  <= 1'b0;
        end else if (fire) begin
            if (item_last) begin
                // The closing byte returns all packet state to its idle value.
                pend_reg    <= '0;
                partial_reg <= '0;
                count_reg   <= '0;
                error_reg   <= 1'b0;
                unused_reg  <= 1'b0;
            end else begin
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
                error_reg   <= error_next;
                unused_reg  <= unused_next;
            end
        end
    end

    a_error_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |-> pend_reg == '0)
        else $error("error state with a code still in progress");

    a_idle_partial_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == '0 |-> partial_reg == '0)
        else $error("payload left over with no code in progress");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item_last |=> count_reg == '0 && !error_reg && !unused_reg)
        else $error("packet state not cleared after last byte");

endmodule

// ===== sv/fpvd_out_stage.sv =====
module fpvd_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  fpvd_pkg::fpvd_result_t              result,
    output logic                                can_load,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fpvd_pkg::OutDataWidth-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser
);

    logic                   valid_reg;
    fpvd_pkg::fpvd_result_t data_reg;

    assign can_load = !valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(fpvd_pkg::OutDataWidth - fpvd_pkg::LengthWidth
                              - fpvd_pkg::StatusWidth){1'b0}},
                            data_reg.final_status, data_reg.pulse_length};
    assign m_axis_tlast  = data_reg.packet_done;
    assign m_axis_tuser  = data_reg.pulse_valid;

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> can_load)
        else $error("result pushed over an unsent transfer");

    a_result_meaningful: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.pulse_valid || data_reg.packet_done)
        else $error("empty result presented");

    a_status_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.packet_done |-> data_reg.final_status == fpvd_pkg::STATUS_OK)
        else $error("status reported before packet end");

endmodule

// ===== sv/flux_pulse_varint_decoder_unit.sv =====
// Decodes a packet of prefix-varint flux bytes into pulse lengths, taking one
// byte per cycle with no bubbles: a byte is registered on input, decoded against
// the packet state combinationally and the result is registered on output, so
// throughput is one byte per cycle whenever the output side keeps up. A transfer
// comes out for each completed pulse (tuser high) and for the byte marked tlast,
// which carries the packet's final status and clears all packet state. Write the
// expected pulse count through cfg_wr_en/cfg_wr_data only while no packet is in
// flight.
module flux_pulse_varint_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fpvd_pkg::LimitWidth-1:0]     cfg_wr_data,   // pulse_limit
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fpvd_pkg::ByteWidth-1:0]      s_axis_tdata,  // [7:0] code_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [27:0] pulse_length, [29:28] final_status, [31:30] zero
    output logic [fpvd_pkg::OutDataWidth-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,  // packet_done
    output logic                                m_axis_tuser   // [0] pulse_valid
);

    logic                           item_valid;
    logic [fpvd_pkg::ByteWidth-1:0] item_byte;
    logic                           item_last;
    logic                           has_result;
    logic                           can_load;
    logic                           advance;
    logic                           push;
    fpvd_pkg::fpvd_result_t         result;

    // A byte that yields no transfer moves on even when the output is full.
    assign advance = item_valid && (!has_result || can_load);
    assign push    = advance && has_result;

    fpvd_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item_byte     (item_byte),
        .item_last     (item_last)
    );

    fpvd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .item_byte   (item_byte),
        .item_last   (item_last),
        .has_result  (has_result),
        .result      (result)
    );

    fpvd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned SettleCycles = 8;
    localparam int          FlawNone     = 0;
    localparam int          FlawBadLead  = 1;
    localparam int          FlawCutOff   = 2;

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              cfg_wr_en     = 1'b0;
    logic [fpvd_pkg::LimitWidth-1:0]   cfg_wr_data   = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [fpvd_pkg::ByteWidth-1:0]    s_axis_tdata  = '0;
    logic                              s_axis_tlast  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [fpvd_pkg::OutDataWidth-1:0] m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              m_axis_tuser;

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int bytes_sent     = 0;
    int limits_written = 0;
    int unsigned cycle_count = 0;

    // Mirrors the decoder's packet state and queues the transfers it owes.
    class pulse_scoreboard;
        logic [fpvd_pkg::LimitWidth-1:0]  pulse_limit;
        logic [fpvd_pkg::PendWidth-1:0]   owed;
        logic [fpvd_pkg::LengthWidth-1:0] partial;
        logic [fpvd_pkg::LimitWidth-1:0]  decoded;
        bit                               halted;
        bit                               overrun;
        fpvd_pkg::fpvd_result_t           expected_pulses[$];
        int                               failures;
        int                               pulses_checked;
        int                               status_count[4];

        function new();
            pulse_limit    = '0;
            failures       = 0;
            pulses_checked = 0;
            status_count   = '{default: 0};
            clear_packet();
        endfunction

        function void clear_packet();
            owed    = '0;
            partial = '0;
            decoded = '0;
            halted  = 1'b0;
            overrun = 1'b0;
        endfunction

        function void note_byte(logic [fpvd_pkg::ByteWidth-1:0] b, logic last);
            fpvd_pkg::fpvd_result_t           r;
            bit                               valid;
            logic [fpvd_pkg::LengthWidth-1:0] len;
            logic [fpvd_pkg::StatusWidth-1:0] st;
            valid = 1'b0;
            len   = '0;
            st    = fpvd_pkg::STATUS_OK;
            if (halted) begin
                // Decoding stopped on a bad lead byte; only tlast matters now.
            end else if (owed != 0) begin
                partial = {partial[fpvd_pkg::LengthWidth-9:0], b};
                owed--;
                if (owed == 0) begin
                    valid   = 1'b1;
                    len     = partial;
                    partial = '0;
                end
            end else if (decoded >= pulse_limit) begin
                overrun = 1'b1;
            end else if ((b & fpvd_pkg::LEAD1_MASK) == '0) begin
                valid = 1'b1;
                len   = fpvd_pkg::LengthWidth'(b);
            end else if ((b & fpvd_pkg::LEAD2_MASK) == fpvd_pkg::LEAD2_CODE) begin
                partial = fpvd_pkg::LengthWidth'(b & fpvd_pkg::PAY2_MASK);
                owed    = 2'd1;
            end else if ((b & fpvd_pkg::LEAD3_MASK) == fpvd_pkg::LEAD3_CODE) begin
                partial = fpvd_pkg::LengthWidth'(b & fpvd_pkg::PAY3_MASK);
                owed    = 2'd2;
            end else if ((b & fpvd_pkg::LEAD4_MASK) == fpvd_pkg::LEAD4_CODE) begin
                partial = fpvd_pkg::LengthWidth'(b & fpvd_pkg::PAY4_MASK);
                owed    = 2'd3;
            end else begin
                halted = 1'b1;
            end
            if (valid)
                decoded++;
            if (last) begin
                if (halted || owed != 0)
                    st = fpvd_pkg::STATUS_ENC_ERROR;
                else if (overrun)
                    st = fpvd_pkg::STATUS_UNUSED;
                else if (decoded != pulse_limit)
                    st = fpvd_pkg::STATUS_SHORT;
                clear_packet();
            end
            if (valid || last) begin
                r.pulse_valid  = valid;
                r.pulse_length = len;
                r.packet_done  = last;
                r.final_status = st;
                expected_pulses.insert(expected_pulses.size(), r);
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void compare_result(logic [fpvd_pkg::OutDataWidth-1:0] data, logic done,
                                     logic pulse);
            fpvd_pkg::fpvd_result_t want;
            if (expected_pulses.size() == 0) begin
                failures++;
                $display("%0t: unexpected transfer, expected none, actual data 0x%0h last %b user %b",
                         $time, data, done, pulse);
                return;
            end
            want = expected_pulses.pop_front();
            check_field("pulse_valid", want.pulse_valid, pulse);
            check_field("pulse_length", want.pulse_length, data[fpvd_pkg::LengthWidth-1:0]);
            check_field("packet_done", want.packet_done, done);
            check_field("final_status", want.final_status,
                        data[fpvd_pkg::LengthWidth+:fpvd_pkg::StatusWidth]);
            check_field("tdata padding", '0,
                        data[fpvd_pkg::OutDataWidth-1:fpvd_pkg::LengthWidth+fpvd_pkg::StatusWidth]);
            if (want.pulse_valid)
                pulses_checked++;
            if (want.packet_done)
                status_count[want.final_status]++;
        endfunction
    endclass

    pulse_scoreboard sb = new();

    flux_pulse_varint_decoder_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Run stopped after %0d cycles with %0d transfers outstanding.",
                     cycle_count, sb.expected_pulses.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.compare_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Output backpressure comes in random bursts while stalls are enabled.
    initial begin : sink_control
        forever begin
            @(posedge aclk);
            if (rx_stalls && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // tvalid stays high across back-to-back transfers; it drops only for a gap or in wait_idle.
    task automatic push_byte(input logic [fpvd_pkg::ByteWidth-1:0] b, input logic last);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge aclk);
        while (s_axis_tready !== 1'b1);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_pulses.size() != 0)
            @(posedge aclk);
        // Ignored bytes leave no transfer behind, so give the pipeline time to empty.
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [fpvd_pkg::LimitWidth-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.pulse_limit = value;
        limits_written++;
    endtask

    function automatic void append_code(ref logic [fpvd_pkg::ByteWidth-1:0] q[$],
                                        input int unsigned nbytes,
                                        input logic [fpvd_pkg::LengthWidth-1:0] v);
        case (nbytes)
            1: q.insert(q.size(), {1'b0, v[6:0]});
            2: begin
                q.insert(q.size(), {2'b10, v[13:8]});
                q.insert(q.size(), v[7:0]);
            end
            3: begin
                q.insert(q.size(), {3'b110, v[20:16]});
                q.insert(q.size(), v[15:8]);
                q.insert(q.size(), v[7:0]);
            end
            default: begin
                q.insert(q.size(), {4'b1110, v[27:24]});
                q.insert(q.size(), v[23:16]);
                q.insert(q.size(), v[15:8]);
                q.insert(q.size(), v[7:0]);
            end
        endcase
    endfunction

    task automatic send_packet(input int n_codes, input int flaw);
        logic [fpvd_pkg::ByteWidth-1:0]   q[$];
        int unsigned                      nb;
        logic [31:0]                      full;
        logic [fpvd_pkg::LengthWidth-1:0] v;
        int                               pick;
        for (int i = 0; i < n_codes; i++) begin
            nb   = $urandom_range(1, 4);
            full = (32'h1 << (7 * nb)) - 1;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = '0;
            else if (pick == 1)
                v = full[fpvd_pkg::LengthWidth-1:0];
            else
                v = fpvd_pkg::LengthWidth'($urandom & full);
            append_code(q, nb, v);
        end
        if (flaw == FlawBadLead) begin
            q.insert($urandom_range(0, q.size()),
                     fpvd_pkg::ByteWidth'(8'hF0 | $urandom_range(0, 15)));
        end else if (flaw == FlawCutOff) begin
            // A multi-byte code missing its tail bytes at the end of the packet.
            nb = $urandom_range(2, 4);
            append_code(q, nb, fpvd_pkg::LengthWidth'($urandom));
            repeat ($urandom_range(1, nb - 1)) q.delete(q.size() - 1);
        end
        if (q.size() == 0)
            q.insert(0, fpvd_pkg::ByteWidth'($urandom_range(0, 255)));
        foreach (q[i])
            push_byte(q[i], i == q.size() - 1);
    endtask

    task automatic run_phase(input int k);
        logic [fpvd_pkg::LimitWidth-1:0] value;
        int                              n;
        int                              flaw;
        case (k % 6)
            0:       value = '0;
            1:       value = 32'd1;
            2:       value = $urandom_range(2, 6);
            3:       value = 32'hFFFF_FFFF;
            4:       value = $urandom_range(7, 12);
            default: value = $urandom | 32'h8000_0000;
        endcase
        wait_idle();
        write_limit(value);
        repeat ($urandom_range(2, 4)) begin
            if (value == 0) begin
                n = $urandom_range(0, 3);
            end else if (value > 12) begin
                n = $urandom_range(1, 10);
            end else begin
                case ($urandom_range(0, 5))
                    0:       n = $urandom_range(0, value - 1);
                    1:       n = value + $urandom_range(1, 3);
                    default: n = value;
                endcase
            end
            case ($urandom_range(0, 7))
                0:       flaw = FlawBadLead;
                1:       flaw = FlawCutOff;
                default: flaw = FlawNone;
            endcase
            send_packet(n, flaw);
        end
    endtask

    // Hand-picked packets for a limit of three, each entry is {tlast, byte}.
    logic [fpvd_pkg::ByteWidth:0] directed[] = '{
        9'h000, 9'h0BF, 9'h0FF, 9'h0EF, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h07F, 9'h0F0, 9'h155,
        9'h0DF, 9'h100,
        9'h080, 9'h000, 9'h0C0, 9'h012, 9'h034, 9'h001, 9'h102,
        9'h1FF,
        9'h105
    };

    initial begin : stimulus
        int phase_idx;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_limit(32'd3);
        foreach (directed[i])
            push_byte(directed[i][fpvd_pkg::ByteWidth-1:0], directed[i][fpvd_pkg::ByteWidth]);
        phase_idx = 0;
        while (bytes_sent < 570) begin
            run_phase(phase_idx);
            phase_idx++;
        end
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        while (bytes_sent < 650) begin
            run_phase(phase_idx);
            phase_idx++;
        end
        wait_idle();
        $display("Sent %0d code bytes under %0d pulse limit settings; %0d pulses checked.",
                 bytes_sent, limits_written, sb.pulses_checked);
        $display("Packet endings: ok %0d, encoding error %0d, unused bytes %0d, short count %0d.",
                 sb.status_count[fpvd_pkg::STATUS_OK],
                 sb.status_count[fpvd_pkg::STATUS_ENC_ERROR],
                 sb.status_count[fpvd_pkg::STATUS_UNUSED],
                 sb.status_count[fpvd_pkg::STATUS_SHORT]);
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
